>>> sv/terrain_mass_balance_index_core_macros.svh
// Assertion macros shared by the mass balance index RTL
`ifndef TERRAIN_MASS_BALANCE_INDEX_CORE_MACROS_SVH
`define TERRAIN_MASS_BALANCE_INDEX_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TMBI_ASSERT_NOW(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define TMBI_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/tmbi_pkg.sv
// Shared constants, types and helper functions of the mass balance index core
package tmbi_pkg;

    // Number formats
    localparam int ELEV_BITS   = 24;
    localparam int FRAC_BITS   = 16;
    localparam int OUT_BITS    = 20;
    localparam int ANG_BITS    = 24;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HALF        = 1 << (FRAC_BITS - 1);

    // Port widths
    localparam int IN_DATA_W   = 6 * ELEV_BITS;
    localparam int IN_USER_W   = 6;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int CS_W        = 16;
    localparam int THR_W       = 32;

    // Datapath widths
    localparam int DIFF_W      = ELEV_BITS + 1;
    localparam int GRAD_W      = DIFF_W + 1;
    localparam int MAG_W       = ELEV_BITS + 1;
    localparam int SUM_W       = ELEV_BITS + 3;
    localparam int MAGS_W      = ELEV_BITS + 2;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int S_W         = SQ_W + 1;
    localparam int C2_W        = 2 * CS_W;
    localparam int FC2_W       = C2_W + 2;
    localparam int PC_W        = THR_W + C2_W;
    localparam int CURV_SHIFT  = 20;
    localparam int HGT_SHIFT   = 12;
    localparam int SLOPE_SHIFT = 16;
    localparam int XC_W        = MAGS_W + CURV_SHIFT;
    localparam int XH_W        = ELEV_BITS + HGT_SHIFT;

    // Divider: floor(n * 2^DIV_STEPS / d) for n <= d
    localparam int DIV_W       = 62;
    localparam int DIV_STEPS   = 32;
    localparam int Q_W         = DIV_STEPS + 1;
    localparam int DIV_LAT     = DIV_STEPS + 1;
    localparam int RATIO_W     = FRAC_BITS + 1;

    // Square root and CORDIC
    localparam int SQRT_STEPS  = 17;
    localparam int SQRT_W      = Q_W + 1;
    localparam int ROOT_W      = 17;
    localparam int CORDIC_STEPS = 24;
    localparam int VEC_BITS    = 30;
    localparam int CV_W        = VEC_BITS + 4;
    localparam int Z_W         = 28;
    localparam int PI_HALF_Q24 = 26353589;
    localparam int ANGQ_W      = 17;

    // Combine stage widths
    localparam int TERM_W      = FRAC_BITS + 2;
    localparam int FACT_W      = FRAC_BITS + 3;
    localparam int M_W         = OUT_BITS;
    localparam int P1_W        = TERM_W + FACT_W;
    localparam int P2_W        = M_W + FACT_W;

    // Pipeline stage numbers (stage 1 is the input register)
    localparam int ST_FRONT    = 5;
    localparam int ST_RDIV     = ST_FRONT + DIV_LAT;
    localparam int ST_ROOT     = ST_RDIV + SQRT_STEPS;
    localparam int ST_CORD     = ST_ROOT + CORDIC_STEPS;
    localparam int ST_ANG      = ST_CORD + 1;
    localparam int ST_SIN      = ST_ANG + 1;
    localparam int ST_SDIV     = ST_SIN + DIV_LAT;
    localparam int ST_F1       = ST_SDIV + 1;
    localparam int ST_F2       = ST_F1 + 1;
    localparam int ST_LAST     = ST_F2 + 1;

    localparam logic signed [Z_W-1:0] ATAN_HEAD [8] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_SIZE  = 3'd0,
        CFG_SLOPE_THR  = 3'd1,
        CFG_CURVE_THR  = 3'd2,
        CFG_HEIGHT_THR = 3'd3,
        CFG_USE_HEIGHT = 3'd4
    } cfg_idx_t;

    // Per-item flags and terms that ride along the pipeline
    typedef struct packed {
        logic                     nodata;
        logic                     sum_pos;
        logic                     rel_neg;
        logic                     big;
        logic                     flat;
        logic                     czero;
        logic                     hzero;
        logic                     szero;
        logic signed [TERM_W-1:0] ct;
        logic signed [TERM_W-1:0] ht;
    } side_t;

    // CORDIC rotation angle of step i in Q24
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        if (i < 8)
            return ATAN_HEAD[i];
        return Z_W'(1) << (ANG_BITS - i);
    endfunction

    // Squash result: round half up of floor(x*2^(F+1)/d) over two
    function automatic logic [RATIO_W-1:0] round_sq(input logic [Q_W-1:0] q,
                                                    input logic zero);
        logic [Q_W-1:0] t;
        t = (q >> (DIV_STEPS - FRAC_BITS - 1)) + Q_W'(1);
        return zero ? '0 : RATIO_W'(t >> 1);
    endfunction

endpackage

>>> sv/tmbi_div.sv
// Pipelined restoring divider: one quotient bit per stage
module tmbi_div (
    input  logic                       clk,
    input  logic                       en,
    input  logic [tmbi_pkg::DIV_W-1:0] num,
    input  logic [tmbi_pkg::DIV_W-1:0] den,
    output logic [tmbi_pkg::Q_W-1:0]   quo
);
    import tmbi_pkg::*;

    logic [DIV_W-1:0] rem_reg  [0:DIV_STEPS];
    logic [DIV_W-1:0] rem_next [0:DIV_STEPS];
    logic [Q_W-1:0]   quo_reg  [0:DIV_STEPS];
    logic [Q_W-1:0]   quo_next [0:DIV_STEPS];
    logic [DIV_W-1:0] den_reg  [0:DIV_STEPS-1];

    // Integer bit: numerator never exceeds the divisor
    always_comb
    begin
        if (num >= den)
        begin
            rem_next[0] = num - den;
            quo_next[0] = Q_W'(1);
        end
        else
        begin
            rem_next[0] = num;
            quo_next[0] = '0;
        end
    end

    // Fraction bits: shift, compare, subtract
    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [DIV_W:0] shifted;
        logic [DIV_W:0] den_ext;
        assign shifted = {rem_reg[i-1], 1'b0};
        assign den_ext = {1'b0, den_reg[i-1]};
        always_comb
        begin
            if (shifted >= den_ext)
            begin
                rem_next[i] = DIV_W'(shifted - den_ext);
                quo_next[i] = {quo_reg[i-1][Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = DIV_W'(shifted);
                quo_next[i] = {quo_reg[i-1][Q_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
            den_reg[0] <= den;
            for (int i = 1; i < DIV_STEPS; i++)
                den_reg[i] <= den_reg[i-1];
        end
    end

    assign quo = quo_reg[DIV_STEPS];

endmodule

>>> sv/tmbi_isqrt.sv
// Pipelined integer square root: one result bit per stage
module tmbi_isqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tmbi_pkg::Q_W-1:0]    val,
    output logic [tmbi_pkg::ROOT_W-1:0] root
);
    import tmbi_pkg::*;

    logic [SQRT_W-1:0] v_in   [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] r_in   [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] v_next [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] r_next [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] v_reg  [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] r_reg  [0:SQRT_STEPS-1];

    assign v_in[0] = SQRT_W'(val);
    assign r_in[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [SQRT_W-1:0] trial;
        if (j > 0)
        begin : g_link
            assign v_in[j] = v_reg[j-1];
            assign r_in[j] = r_reg[j-1];
        end
        assign trial = r_in[j] + BIT;
        // Take the bit when the remainder covers the trial value
        always_comb
        begin
            if (v_in[j] >= trial)
            begin
                v_next[j] = v_in[j] - trial;
                r_next[j] = (r_in[j] >> 1) + BIT;
            end
            else
            begin
                v_next[j] = v_in[j];
                r_next[j] = r_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                v_reg[j] <= v_next[j];
                r_reg[j] <= r_next[j];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

>>> sv/tmbi_cordic.sv
// Pipelined CORDIC vectoring: arctangent of a Q16 ratio in Q24
module tmbi_cordic (
    input  logic                            clk,
    input  logic                            en,
    input  logic [tmbi_pkg::ROOT_W-1:0]     ratio,
    output logic signed [tmbi_pkg::Z_W-1:0] angle
);
    import tmbi_pkg::*;

    logic signed [CV_W-1:0] x_in   [0:CORDIC_STEPS-1];
    logic signed [CV_W-1:0] y_in   [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  z_in   [0:CORDIC_STEPS-1];
    logic signed [CV_W-1:0] x_next [0:CORDIC_STEPS-1];
    logic signed [CV_W-1:0] y_next [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  z_next [0:CORDIC_STEPS-1];
    logic signed [CV_W-1:0] x_reg  [0:CORDIC_STEPS-1];
    logic signed [CV_W-1:0] y_reg  [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  z_reg  [0:CORDIC_STEPS-1];
    logic [CORDIC_STEPS-1:0] zero_reg;

    assign x_in[0] = $signed(CV_W'(1) << VEC_BITS);
    assign y_in[0] = $signed(CV_W'(ratio) << (VEC_BITS - FRAC_BITS));
    assign z_in[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [Z_W-1:0] STEP = atan_step(i);
        if (i > 0)
        begin : g_link
            assign x_in[i] = x_reg[i-1];
            assign y_in[i] = y_reg[i-1];
            assign z_in[i] = z_reg[i-1];
        end
        // Rotate toward the x axis
        always_comb
        begin
            if (!y_in[i][CV_W-1])
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + STEP;
            end
            else
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - STEP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
            zero_reg <= {zero_reg[CORDIC_STEPS-2:0], (ratio == '0)};
        end
    end

    // A zero ratio has angle zero
    assign angle = zero_reg[CORDIC_STEPS-1] ? '0 : z_reg[CORDIC_STEPS-1];

endmodule

>>> sv/terrain_mass_balance_index_core.sv
// Top level of the mass balance index core: front end, dividers, angle and combine
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata elevations, s_tuser valid/in-grid flags
//  m_      | out | m_tvalid/m_tready  | m_tdata index Q16, m_tuser nodata flag
//  cfg_    | in  | cfg_we             | cfg_index, cfg_data
//
//  One item enters per cycle while no result waits on m_tready.
//  The path runs through the two 33-stage dividers, the 17-stage square root
//  and the 24-stage CORDIC in series. rst_n clears the valid bits and loads the
//  configuration registers with their defaults. All stages hold together while a
//  result waits on m_tready; bubbles in flight are kept as they are.
`include "terrain_mass_balance_index_core_macros.svh"

module terrain_mass_balance_index_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // centre_elev, north_elev, east_elev, south_elev, west_elev, rel_height
    input  logic [tmbi_pkg::IN_DATA_W-1:0]  s_tdata,
    // centre_valid, north_in, east_in, south_in, west_in, rel_height_valid
    input  logic [tmbi_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // mbi_value, zero fill
    output logic [tmbi_pkg::OUT_DATA_W-1:0] m_tdata,
    // no_data
    output logic [tmbi_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                            cfg_we,
    input  logic [tmbi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmbi_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tmbi_pkg::*;

    // Configuration
    logic [CS_W-1:0]  cell_size_reg;
    logic [THR_W-1:0] slope_thr_reg;
    logic [THR_W-1:0] curve_thr_reg;
    logic [THR_W-1:0] height_thr_reg;
    logic             use_height_reg;

    // Control
    logic               en;
    logic [ST_LAST:1]   valid_reg;
    side_t              side_in;
    side_t              side_reg  [1:ST_LAST];
    side_t              side_next [1:ST_LAST];

    // Input fields
    logic signed [ELEV_BITS-1:0] centre_elev, north_elev, east_elev;
    logic signed [ELEV_BITS-1:0] south_elev, west_elev, rel_height;
    logic centre_valid, north_in, east_in, south_in, west_in, rel_height_valid;

    // Front stages
    logic signed [DIFF_W-1:0]    zm0_reg, zm2_reg, zm4_reg, zm6_reg;
    logic signed [ELEV_BITS-1:0] rel1_reg;
    logic signed [GRAD_W-1:0]    grad_a, grad_b;
    logic signed [SUM_W-1:0]     sum_all;
    logic signed [DIFF_W-1:0]    rel_ext;
    logic [CS_W-1:0]             cell_eff;
    logic [MAG_W-1:0]            ua_reg, ub_reg;
    logic [MAGS_W-1:0]           sum_mag2_reg, sum_mag3_reg;
    logic [ELEV_BITS-1:0]        rel_mag2_reg, rel_mag3_reg;
    logic [C2_W-1:0]             c2_reg;
    logic [SQ_W-1:0]             sqa_reg, sqb_reg;
    logic [PC_W-1:0]             pc_reg;
    logic [FC2_W-1:0]            four_c2_3_reg, four_c2_4_reg;
    logic [S_W-1:0]              s_reg;
    logic [1:0]                  halve;
    logic [DIV_W-1:0]            pck_reg, xck_reg;
    logic [XH_W-1:0]             xh4_reg;
    logic                        big_next;
    logic [DIV_W-1:0]            nr_reg, dr_reg, xc5_reg, dc_reg, xh5_reg, dh_reg;
    logic [DIV_W-1:0]            dc_next, dh_next;

    // Divider, root and angle path
    logic [Q_W-1:0]              rdiv_q, cdiv_q, hdiv_q, sdiv_q;
    logic [ROOT_W-1:0]           root;
    logic signed [Z_W-1:0]       cord_z;
    logic signed [Z_W-1:0]       ang_full;
    logic signed [Z_W-1:0]       ang_clamp;
    logic [ANGQ_W-1:0]           ang_reg;
    logic [DIV_W-1:0]            xs_reg, ds_reg;
    logic [DIV_W-1:0]            xs_next, ds_next;
    logic [RATIO_W-1:0]          cq, hq, sq;

    // Combine stages
    logic signed [TERM_W-1:0]    st_s;
    logic signed [FACT_W-1:0]    f1_reg, f2_reg;
    logic signed [P1_W-1:0]      prod1, rnd1;
    logic signed [M_W-1:0]       m1_reg;
    logic signed [P2_W-1:0]      prod2, rnd2;
    logic signed [M_W-1:0]       mbi_reg;
    logic                        nodata_reg;

    // Unpack the input item
    assign centre_elev      = s_tdata[ELEV_BITS-1:0];
    assign north_elev       = s_tdata[2*ELEV_BITS-1:ELEV_BITS];
    assign east_elev        = s_tdata[3*ELEV_BITS-1:2*ELEV_BITS];
    assign south_elev       = s_tdata[4*ELEV_BITS-1:3*ELEV_BITS];
    assign west_elev        = s_tdata[5*ELEV_BITS-1:4*ELEV_BITS];
    assign rel_height       = s_tdata[6*ELEV_BITS-1:5*ELEV_BITS];
    assign centre_valid     = s_tuser[0];
    assign north_in         = s_tuser[1];
    assign east_in          = s_tuser[2];
    assign south_in         = s_tuser[3];
    assign west_in          = s_tuser[4];
    assign rel_height_valid = s_tuser[5];

    // Neighbour difference with fallback to the opposite side
    function automatic logic signed [DIFF_W-1:0] pick(
        input logic                        own_in,
        input logic signed [ELEV_BITS-1:0] own,
        input logic                        opp_in,
        input logic signed [ELEV_BITS-1:0] opp,
        input logic signed [ELEV_BITS-1:0] ctr
    );
        if (own_in)
            return DIFF_W'(own) - DIFF_W'(ctr);
        if (opp_in)
            return DIFF_W'(ctr) - DIFF_W'(opp);
        return '0;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg  <= CS_W'(480);
            slope_thr_reg  <= THR_W'(983040);
            curve_thr_reg  <= THR_W'(655);
            height_thr_reg <= THR_W'(983040);
            use_height_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CELL_SIZE:  cell_size_reg  <= cfg_data[CS_W-1:0];
                CFG_SLOPE_THR:  slope_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_CURVE_THR:  curve_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_HEIGHT_THR: height_thr_reg <= cfg_data[THR_W-1:0];
                CFG_USE_HEIGHT: use_height_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output item is stalled
    assign en       = !valid_reg[ST_LAST] || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[ST_LAST-1:1], s_tvalid};
    end

    // Flags known at entry
    always_comb
    begin
        side_in         = '0;
        side_in.nodata  = !centre_valid || (use_height_reg && !rel_height_valid);
        side_in.rel_neg = rel_height[ELEV_BITS-1];
    end

    // Front-end arithmetic
    assign grad_a   = GRAD_W'(zm0_reg) - GRAD_W'(zm4_reg);
    assign grad_b   = GRAD_W'(zm2_reg) - GRAD_W'(zm6_reg);
    assign sum_all  = SUM_W'(zm0_reg) + SUM_W'(zm2_reg) + SUM_W'(zm4_reg) + SUM_W'(zm6_reg);
    assign rel_ext  = DIFF_W'(rel1_reg);
    assign cell_eff = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;

    // Halve curvature operands until they fit below 2^61
    always_comb
    begin
        if (pc_reg[PC_W-1])
            halve = 2'd3;
        else if (pc_reg[PC_W-2])
            halve = 2'd2;
        else if (pc_reg[PC_W-3])
            halve = 2'd1;
        else
            halve = 2'd0;
    end

    assign big_next = S_W'(four_c2_4_reg) < s_reg;
    assign dc_next  = pck_reg + xck_reg;
    assign dh_next  = DIV_W'(height_thr_reg) + DIV_W'(xh4_reg);

    // Stages 1 to 5: differences, magnitudes, squares, operand selection
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zm0_reg  <= pick(north_in, north_elev, south_in, south_elev, centre_elev);
            zm4_reg  <= pick(south_in, south_elev, north_in, north_elev, centre_elev);
            zm2_reg  <= pick(east_in, east_elev, west_in, west_elev, centre_elev);
            zm6_reg  <= pick(west_in, west_elev, east_in, east_elev, centre_elev);
            rel1_reg <= rel_height;

            ua_reg       <= MAG_W'(grad_a[GRAD_W-1] ? -grad_a : grad_a);
            ub_reg       <= MAG_W'(grad_b[GRAD_W-1] ? -grad_b : grad_b);
            sum_mag2_reg <= MAGS_W'(sum_all[SUM_W-1] ? -sum_all : sum_all);
            rel_mag2_reg <= ELEV_BITS'(rel_ext[DIFF_W-1] ? -rel_ext : rel_ext);
            c2_reg       <= C2_W'(cell_eff) * C2_W'(cell_eff);

            sqa_reg       <= SQ_W'(ua_reg) * SQ_W'(ua_reg);
            sqb_reg       <= SQ_W'(ub_reg) * SQ_W'(ub_reg);
            pc_reg        <= PC_W'(curve_thr_reg) * PC_W'(c2_reg);
            four_c2_3_reg <= {c2_reg, 2'b00};
            sum_mag3_reg  <= sum_mag2_reg;
            rel_mag3_reg  <= rel_mag2_reg;

            s_reg         <= S_W'(sqa_reg) + S_W'(sqb_reg);
            pck_reg       <= DIV_W'(pc_reg >> halve);
            xck_reg       <= DIV_W'({sum_mag3_reg, CURV_SHIFT'(0)} >> halve);
            xh4_reg       <= {rel_mag3_reg, HGT_SHIFT'(0)};
            four_c2_4_reg <= four_c2_3_reg;

            nr_reg  <= big_next ? DIV_W'(four_c2_4_reg) : DIV_W'(s_reg);
            dr_reg  <= big_next ? DIV_W'(s_reg) : DIV_W'(four_c2_4_reg);
            xc5_reg <= xck_reg;
            dc_reg  <= dc_next;
            xh5_reg <= DIV_W'(xh4_reg);
            dh_reg  <= dh_next;
        end
    end

    // Ratio and the curvature and height squash divisions run side by side
    tmbi_div u_rdiv (.clk(clk), .en(en), .num(nr_reg),  .den(dr_reg), .quo(rdiv_q));
    tmbi_div u_cdiv (.clk(clk), .en(en), .num(xc5_reg), .den(dc_reg), .quo(cdiv_q));
    tmbi_div u_hdiv (.clk(clk), .en(en), .num(xh5_reg), .den(dh_reg), .quo(hdiv_q));

    tmbi_isqrt u_isqrt (.clk(clk), .en(en), .val(rdiv_q), .root(root));
    tmbi_cordic u_cordic (.clk(clk), .en(en), .ratio(root), .angle(cord_z));

    assign cq = round_sq(cdiv_q, side_reg[ST_RDIV].czero);
    assign hq = round_sq(hdiv_q, side_reg[ST_RDIV].hzero);

    // Fold the angle back when the gradient exceeded twice the cell size; clamp to 0..pi/2
    always_comb
    begin
        ang_full = side_reg[ST_CORD].big ? (Z_W'(PI_HALF_Q24) - cord_z) : cord_z;
        if (side_reg[ST_CORD].flat || ang_full[Z_W-1])
            ang_clamp = '0;
        else if (ang_full > Z_W'(PI_HALF_Q24))
            ang_clamp = Z_W'(PI_HALF_Q24);
        else
            ang_clamp = ang_full;
    end

    assign xs_next = DIV_W'(ang_reg) << SLOPE_SHIFT;
    assign ds_next = (DIV_W'(slope_thr_reg) << FRAC_BITS) + xs_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= ANGQ_W'((ang_clamp + Z_W'(1 << (ANG_BITS - FRAC_BITS - 1)))
                               >>> (ANG_BITS - FRAC_BITS));
            xs_reg  <= xs_next;
            ds_reg  <= ds_next;
        end
    end

    tmbi_div u_sdiv (.clk(clk), .en(en), .num(xs_reg), .den(ds_reg), .quo(sdiv_q));

    // Carry flags and terms along, filling fields as they become known
    always_comb
    begin
        side_next[1] = side_in;
        for (int k = 2; k <= ST_LAST; k++)
            side_next[k] = side_reg[k-1];
        side_next[2].sum_pos       = !sum_all[SUM_W-1] && (sum_all != '0);
        side_next[ST_FRONT].big    = big_next;
        side_next[ST_FRONT].flat   = (s_reg == '0);
        side_next[ST_FRONT].czero  = (dc_next == '0);
        side_next[ST_FRONT].hzero  = (dh_next == '0);
        side_next[ST_RDIV+1].ct    = side_reg[ST_RDIV].sum_pos ?
                                     -TERM_W'(cq) : TERM_W'(cq);
        side_next[ST_RDIV+1].ht    = side_reg[ST_RDIV].rel_neg ?
                                     -TERM_W'(hq) : TERM_W'(hq);
        side_next[ST_SIN].szero    = (ds_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k <= ST_LAST; k++)
                side_reg[k] <= side_next[k];
        end
    end

    // Combine: curvature times slope factor, then times height factor when use_height is set
    assign sq    = round_sq(sdiv_q, side_reg[ST_SDIV].szero);
    assign st_s  = TERM_W'(sq);
    assign prod1 = P1_W'(side_reg[ST_F1].ct) * P1_W'(f1_reg);
    assign rnd1  = prod1 + P1_W'(HALF);
    assign prod2 = P2_W'(m1_reg) * P2_W'(f2_reg);
    assign rnd2  = prod2 + P2_W'(HALF);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= side_reg[ST_SDIV].ct[TERM_W-1] ?
                      (FACT_W'(ONE) - FACT_W'(st_s)) : (FACT_W'(ONE) + FACT_W'(st_s));

            m1_reg <= M_W'(rnd1 >>> FRAC_BITS);
            f2_reg <= side_reg[ST_F1].ct[TERM_W-1] ?
                      (FACT_W'(ONE) - FACT_W'(side_reg[ST_F1].ht)) :
                      (FACT_W'(ONE) + FACT_W'(side_reg[ST_F1].ht));

            nodata_reg <= side_reg[ST_F2].nodata;
            if (side_reg[ST_F2].nodata)
                mbi_reg <= '0;
            else if (use_height_reg)
                mbi_reg <= M_W'(rnd2 >>> FRAC_BITS);
            else
                mbi_reg <= m1_reg;
        end
    end

    assign m_tvalid = valid_reg[ST_LAST];
    assign m_tdata  = OUT_DATA_W'(unsigned'(mbi_reg));
    assign m_tuser  = nodata_reg;

    `TMBI_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !en, valid_reg == $past(valid_reg), "pipeline moved while stalled")
    `TMBI_ASSERT_NOW(a_index_range, clk, rst_n, m_tvalid && !nodata_reg, mbi_reg >= -131072 && mbi_reg <= 262144, "index out of range")
    `TMBI_ASSERT_NOW(a_nodata_zero, clk, rst_n, m_tvalid && nodata_reg, mbi_reg == '0, "nodata item carries a value")
    `TMBI_ASSERT_NOW(a_slope_factor, clk, rst_n, valid_reg[ST_F1], f1_reg >= 0 && f1_reg <= 2 * ONE, "slope factor out of range")

endmodule
